// ----- design/rsd_pkg.sv -----
package rsd_pkg;

  localparam int SUM_WIDTH   = 57;  // q33.24 accumulator
  localparam int LEN_WIDTH   = 9;   // row length register and sample count
  localparam int DEV_WIDTH   = 25;  // q13.12 deviation
  localparam int ROOT_WIDTH  = 29;  // bits of floor(sqrt()) of a 57-bit value
  localparam int RREM_WIDTH  = ROOT_WIDTH + 2;
  localparam int RAD_WIDTH   = 2 * ROOT_WIDTH;
  localparam int DIV_STEPS   = SUM_WIDTH;
  localparam int ROOT_STEPS  = ROOT_WIDTH;
  localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QLVL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // one finished row waiting for division and root
  typedef struct packed {
    logic [SUM_WIDTH-1:0] sum;
    logic [LEN_WIDTH-1:0] len;
  } rsd_job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic [QLVL_WIDTH-1:0] level;
    logic                  empty;
  } rsd_qstat_t;

endpackage

// ----- design/row_standard_deviation_core.sv -----
// row standard deviation core: takes one q12.12 sample and its row mean per transaction,
// accumulates the squared differences over row_length samples and returns
// floor(sqrt(floor(sum / n))) as one q13.12 deviation per row. the front end takes a
// transaction every cycle while the queue has room (difference, square and accumulate
// stages); each finished row goes through a four-row queue to a back end with a bit-serial
// divider and a bit-serial root, which finishes one row (57 division steps, 29 root steps,
// load and hand-over) before it takes the next. rows longer than one back-end pass stream
// at one sample a cycle; shorter rows are paced by the back end once the queue has filled.
// row_length is written through cfg_we/cfg_wdata, zero counts as one, values beyond
// MAX_ROW_LENGTH are clamped, and a change mid-row applies from the next sample on.
module row_standard_deviation_core #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rsd_pkg::LEN_WIDTH-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_value,
  input  logic signed [SAMPLE_WIDTH-1:0]  row_mean,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsd_pkg::DEV_WIDTH-1:0]   deviation
);
  import rsd_pkg::*;

  logic [LEN_WIDTH-1:0] row_length;
  logic                 push;
  rsd_job_t             push_job;
  logic                 pop;
  rsd_job_t             head;
  rsd_qstat_t           qstat;

  // row length register, one after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_WIDTH'(1);
    end else if (cfg_we) begin
      row_length <= cfg_wdata;
    end
  end

  // front end: accepts transactions, counts the row, squares and accumulates
  rsd_front #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .row_mean     (row_mean),
    .row_length   (row_length),
    .qstat        (qstat),
    .push         (push),
    .push_job     (push_job)
  );

  // finished row sums waiting for the back end
  rsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // back end: divide by the row length, floor root, output register
  rsd_root u_root (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .deviation (deviation)
  );

  // the front end's reservation must keep the queue from ever overfilling
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= QLVL_WIDTH'(QUEUE_DEPTH))
    else $error("queue level beyond its depth");

endmodule

// ----- design/rsd_front.sv -----
module rsd_front #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_value,
  input  logic signed [SAMPLE_WIDTH-1:0]   row_mean,
  input  logic [rsd_pkg::LEN_WIDTH-1:0]    row_length,
  input  rsd_pkg::rsd_qstat_t              qstat,
  output logic                             push,
  output rsd_pkg::rsd_job_t                push_job
);
  import rsd_pkg::*;

  localparam int DiffW = SAMPLE_WIDTH + 1;
  localparam int ProdW = 2 * DiffW;

  logic                    accept;
  logic [LEN_WIDTH-1:0]    eff_len;
  logic [LEN_WIDTH-1:0]    count;
  logic [LEN_WIDTH-1:0]    count_next;
  logic                    row_end;
  logic signed [DiffW-1:0] diff;
  logic [QLVL_WIDTH:0]     reserved;

  logic                    s1_valid;
  logic                    s1_last;
  logic [LEN_WIDTH-1:0]    s1_len;
  logic signed [DiffW-1:0] s1_diff;

  logic signed [ProdW-1:0] prod;
  logic [ProdW+SUM_WIDTH-1:0] prod_ext;

  logic                    s2_valid;
  logic                    s2_last;
  logic [LEN_WIDTH-1:0]    s2_len;
  logic [SUM_WIDTH-1:0]    s2_sq;

  logic [SUM_WIDTH-1:0]    acc;
  logic [SUM_WIDTH-1:0]    acc_sum;

  // zero means one, clamp to the largest row
  always_comb begin
    if (row_length == '0) begin
      eff_len = LEN_WIDTH'(1);
    end else if (int'(row_length) > MAX_ROW_LENGTH) begin
      eff_len = LEN_WIDTH'(MAX_ROW_LENGTH);
    end else begin
      eff_len = row_length;
    end
  end

  // room in the queue for every row end already in flight
  assign reserved = {1'b0, qstat.level} + (QLVL_WIDTH+1)'(s1_valid & s1_last)
                  + (QLVL_WIDTH+1)'(s2_valid & s2_last);
  assign in_ready = reserved < (QLVL_WIDTH+1)'(QUEUE_DEPTH);
  assign accept   = in_valid & in_ready;

  assign count_next = count + LEN_WIDTH'(1);
  assign row_end    = (count_next >= eff_len) || (count_next == '0);
  assign diff       = {sample_value[SAMPLE_WIDTH-1], sample_value}
                    - {row_mean[SAMPLE_WIDTH-1], row_mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= row_end ? '0 : count_next;
    end
  end

  // stage 1: difference
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_diff <= diff;
      s1_last <= row_end;
      s1_len  <= eff_len;
    end
  end

  // stage 2: square, kept modulo the accumulator width
  assign prod     = s1_diff * s1_diff;
  assign prod_ext = {{SUM_WIDTH{1'b0}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sq   <= prod_ext[SUM_WIDTH-1:0];
      s2_last <= s1_last;
      s2_len  <= s1_len;
    end
  end

  // stage 3: accumulate, hand the row over at its end
  assign acc_sum = acc + s2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= s2_last ? '0 : acc_sum;
    end
  end

  assign push          = s2_valid & s2_last;
  assign push_job.sum  = acc_sum;
  assign push_job.len  = s2_len;

endmodule

// ----- design/rsd_queue.sv -----
module rsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rsd_pkg::rsd_job_t   push_job,
  input  logic                pop,
  output rsd_pkg::rsd_job_t   head,
  output rsd_pkg::rsd_qstat_t qstat
);
  import rsd_pkg::*;

  rsd_job_t              mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QLVL_WIDTH-1:0] level;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      end
      level <= level + QLVL_WIDTH'(push) - QLVL_WIDTH'(pop);
    end
  end

  assign head        = mem[rd_ptr];
  assign qstat.level = level;
  assign qstat.empty = (level == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> level < QLVL_WIDTH'(QUEUE_DEPTH))
    else $error("row pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> level != '0)
    else $error("row popped from an empty queue");

endmodule

// ----- design/rsd_root.sv -----
module rsd_root (
  input  logic                           clk,
  input  logic                           rst,
  input  rsd_pkg::rsd_qstat_t            qstat,
  input  rsd_pkg::rsd_job_t              head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsd_pkg::DEV_WIDTH-1:0]  deviation
);
  import rsd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_HOLD = 4'b1000
  } rsd_state_t;

  rsd_state_t             state;
  logic [STEP_WIDTH-1:0]  step;
  logic [RAD_WIDTH-1:0]   work;   // dividend, then quotient, then radicand
  logic [LEN_WIDTH-1:0]   len;
  logic [LEN_WIDTH-1:0]   rem;
  logic [ROOT_WIDTH-1:0]  root;
  logic [RREM_WIDTH-1:0]  rrem;

  logic [LEN_WIDTH:0]     dtrial;
  logic                   dge;
  logic [LEN_WIDTH-1:0]   rem_next;
  logic [RREM_WIDTH-1:0]  rtrial;
  logic [RREM_WIDTH-1:0]  rtest;
  logic                   rge;
  logic                   out_free;

  // restoring division, one quotient bit a cycle
  assign dtrial   = {rem, work[SUM_WIDTH-1]};
  assign dge      = dtrial >= {1'b0, len};
  assign rem_next = dge ? LEN_WIDTH'(dtrial - {1'b0, len}) : dtrial[LEN_WIDTH-1:0];

  // digit-by-digit root, one result bit a cycle
  assign rtrial = {rrem[RREM_WIDTH-3:0], work[RAD_WIDTH-1 -: 2]};
  assign rtest  = {root, 2'b01};
  assign rge    = rtrial >= rtest;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (step == '0) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        work <= {1'b0, head.sum};
        len  <= head.len;
        rem  <= '0;
        step <= STEP_WIDTH'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        work <= {1'b0, work[SUM_WIDTH-2:0], dge};
        rem  <= rem_next;
        if (step == '0) begin
          step <= STEP_WIDTH'(ROOT_STEPS - 1);
          root <= '0;
          rrem <= '0;
        end else begin
          step <= step - STEP_WIDTH'(1);
        end
      end
      ST_ROOT: begin
        work <= {work[RAD_WIDTH-3:0], 2'b00};
        root <= {root[ROOT_WIDTH-2:0], rge};
        rrem <= rge ? rtrial - rtest : rtrial;
        step <= step - STEP_WIDTH'(1);
      end
      ST_HOLD: begin
        if (out_free) begin
          deviation <= root[DEV_WIDTH-1:0];
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < len && len != '0)
    else $error("division remainder out of range");

  a_start_on_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && !qstat.empty |=> state == ST_DIV)
    else $error("waiting row not taken up");

  a_root_headroom: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> work[RAD_WIDTH-1] == 1'b0 || step != STEP_WIDTH'(ROOT_STEPS - 1))
    else $error("radicand exceeds accumulator width");

endmodule
